// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the tag-frame parser.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfp assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfp assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/rfp_pkg.sv
// Types, character codes and the character decoder of the tag-frame parser.
// Depends on nothing; used by every module of the block.
`default_nettype none

package rfp_pkg;

    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_ETX  = 8'h03;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] HEX_A_VALUE = 8'd10;

    localparam int ID_WIDTH = 40;

    typedef enum logic [1:0] {
        FRAME_GOOD    = 2'd0,
        FRAME_BAD_SUM = 2'd1,
        FRAME_ABORT   = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic                in_frame;
        logic [3:0]          char_count;
        logic [3:0]          held_high;
        logic [7:0]          running_xor;
        logic [ID_WIDTH-1:0] id_acc;
    } frame_state_t;

    typedef struct packed {
        frame_status_t       status;
        logic [ID_WIDTH-1:0] tag_id;
        logic [7:0]          checksum;
    } frame_result_t;

    // Hex digits in upper case become their value; any other byte passes unchanged.
    function automatic logic [7:0] char_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            v = c - CH_ZERO;
        end
        else if (c >= CH_A && c <= CH_F)
        begin
            v = c - CH_A + HEX_A_VALUE;
        end
        else
        begin
            v = c;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: src/rfid_ascii_frame_parser_core.sv
// Tag-frame parser for ASCII-hex reader output with XOR checksum (top level).
// Uses rfp_pkg, rfp_frame_step, rfp_result_reg and assert_macros.svh.
//
// Input channel: one received serial byte per beat on rx_byte (in_valid/in_ready).
// Output channel: one result per finished or aborted frame (out_valid/out_ready),
// carrying frame_status, tag_id and received_checksum.
// Bytes outside a frame are dropped until STX opens one; a control byte inside a
// frame aborts it and yields an abort result with zero id and checksum.
// A byte accepted on the input is registered in the input register, decoded
// against the frame state, and its result, if any, is then registered in the
// result register that drives the output channel.
// Throughput is one byte per cycle while no result waits on a full result register,
// set by the single decode stage between the input register and the result register.
// When the receiver stalls, the result register holds its beat; bytes that give
// no result keep flowing, and a byte that would give a result waits in the input
// register, dropping in_ready, until the result register frees up.
// Reset returns the parser to idle with both registers empty.
`default_nettype none

`include "assert_macros.svh"

module rfid_ascii_frame_parser_core #(
    parameter int DATA_BYTES = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       frame_status,
    output logic [39:0]      tag_id,
    output logic [7:0]       received_checksum
);

    localparam logic [3:0] LastCount = 4'(2 * DATA_BYTES + 1);

    logic                   rx_valid_reg;
    logic                   rx_valid_next;
    logic [7:0]             rx_byte_reg;
    rfp_pkg::frame_state_t  state_reg;
    rfp_pkg::frame_state_t  state_next;
    rfp_pkg::frame_result_t step_result;
    rfp_pkg::frame_result_t out_result;
    logic                   step_emit;
    logic                   step_advance;
    logic                   step_fire;
    logic                   out_free;

    rfp_frame_step #(
        .DATA_BYTES (DATA_BYTES)
    ) u_step (
        .rx_byte    (rx_byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    // The registered byte moves on unless it makes a result and the result register is full and not being taken.
    assign step_advance  = !step_emit || out_free;
    assign step_fire     = rx_valid_reg && step_advance;
    assign in_ready      = !rx_valid_reg || step_advance;
    assign rx_valid_next = (in_valid && in_ready) || (rx_valid_reg && !step_advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            rx_valid_reg <= rx_valid_next;
            if (step_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rx_byte_reg <= rx_byte;
        end
    end

    rfp_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_fire && step_emit),
        .data      (step_result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (out_free),
        .held      (out_result)
    );

    assign frame_status      = out_result.status;
    assign tag_id            = out_result.tag_id;
    assign received_checksum = out_result.checksum;

    `ASSERT_IMPLIES(a_abort_zero, clk, rst_n, out_valid && frame_status == rfp_pkg::FRAME_ABORT, tag_id == '0 && received_checksum == '0)
    `ASSERT_IMPLIES(a_idle_count, clk, rst_n, !state_reg.in_frame, state_reg.char_count == '0)
    `ASSERT_IMPLIES(a_count_range, clk, rst_n, state_reg.in_frame, state_reg.char_count <= LastCount)
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !in_ready, rx_valid_reg && step_emit && out_valid && !out_ready)
    `ASSERT_NEXT(a_beat_held, clk, rst_n, in_valid && in_ready, rx_valid_reg)

endmodule

`default_nettype wire

// File: src/rfp_frame_step.sv
// Combinational frame step: next parser state and result for one received byte.
// Depends on rfp_pkg.
`default_nettype none

module rfp_frame_step #(
    parameter int DATA_BYTES = 5
) (
    input  wire logic [7:0]           rx_byte,
    input  wire rfp_pkg::frame_state_t state,
    output rfp_pkg::frame_state_t     state_next,
    output logic                      emit,
    output rfp_pkg::frame_result_t    result
);

    localparam logic [3:0] DataBytes = 4'(DATA_BYTES);

    logic       is_control;
    logic [7:0] value;
    logic [7:0] pair;
    logic [3:0] pair_index;

    assign is_control = (rx_byte == rfp_pkg::CH_STX) || (rx_byte == rfp_pkg::CH_ETX)
                     || (rx_byte == rfp_pkg::CH_CR)  || (rx_byte == rfp_pkg::CH_LF);
    assign value      = rfp_pkg::char_value(rx_byte);
    // Only the low nibble of the held character survives the shift into the pair.
    assign pair       = value | {state.held_high, 4'h0};
    assign pair_index = {1'b0, state.char_count[3:1]};

    always_comb
    begin
        state_next      = state;
        emit            = 1'b0;
        result.status   = rfp_pkg::FRAME_GOOD;
        result.tag_id   = '0;
        result.checksum = '0;
        if (!state.in_frame)
        begin
            if (rx_byte == rfp_pkg::CH_STX)
            begin
                state_next.in_frame    = 1'b1;
                state_next.char_count  = '0;
                state_next.held_high   = '0;
                state_next.running_xor = '0;
                state_next.id_acc      = '0;
            end
        end
        else if (is_control)
        begin
            state_next.in_frame   = 1'b0;
            state_next.char_count = '0;
            emit                  = 1'b1;
            result.status         = rfp_pkg::FRAME_ABORT;
        end
        else if (!state.char_count[0])
        begin
            state_next.held_high  = value[3:0];
            state_next.char_count = state.char_count + 4'd1;
        end
        else if (pair_index < DataBytes)
        begin
            state_next.running_xor = state.running_xor ^ pair;
            state_next.id_acc      = {state.id_acc[rfp_pkg::ID_WIDTH-9:0], pair};
            state_next.char_count  = state.char_count + 4'd1;
        end
        else
        begin
            state_next.in_frame   = 1'b0;
            state_next.char_count = '0;
            emit                  = 1'b1;
            result.status         = (pair == state.running_xor) ? rfp_pkg::FRAME_GOOD
                                                                : rfp_pkg::FRAME_BAD_SUM;
            result.tag_id         = state.id_acc;
            result.checksum       = pair;
        end
    end

endmodule

`default_nettype wire

// File: src/rfp_result_reg.sv
// Output register of the tag-frame parser: holds one result beat until taken.
// Depends on rfp_pkg.
`default_nettype none

module rfp_result_reg (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire rfp_pkg::frame_result_t data,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic                        free,
    output rfp_pkg::frame_result_t      held
);

    logic                   valid_reg;
    logic                   valid_next;
    rfp_pkg::frame_result_t data_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

`default_nettype wire

// File: sim/rfp_frame_checker.sv
// Checker for the tag-frame parser: watches both channels, predicts each frame result
// from the accepted bytes and compares every result beat with the oldest prediction.
// Depends on rfp_pkg for the character codes and the result types.
`default_nettype none

module rfp_frame_checker #(
    parameter int DATA_BYTES = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  frame_status,
    input  wire logic [39:0] tag_id,
    input  wire logic [7:0]  received_checksum,
    output int               fail_count,
    output int               pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdWidth = rfp_pkg::ID_WIDTH;

    logic               parse_active;
    logic [3:0]         char_index;
    logic [7:0]         high_char_value;
    logic [7:0]         frame_xor;
    logic [IdWidth-1:0] id_shift;

    rfp_pkg::frame_result_t expected_frames [$];
    int                     mismatches = 0;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (c >= rfp_pkg::CH_ZERO && c <= rfp_pkg::CH_NINE)
        begin
            v = c - rfp_pkg::CH_ZERO;
        end
        if (c >= rfp_pkg::CH_A && c <= rfp_pkg::CH_F)
        begin
            v = (c - rfp_pkg::CH_A) + rfp_pkg::HEX_A_VALUE;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] frame checker: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_frame();
        rfp_pkg::frame_result_t want;
        if (expected_frames.size() == 0)
        begin
            report_mismatch($sformatf("result beat with none expected (status %0d, id %h)",
                                      frame_status, tag_id));
        end
        else
        begin
            want = expected_frames.pop_front();
            if (frame_status != want.status)
                report_mismatch($sformatf("frame_status %0d, expected %0d",
                                          frame_status, want.status));
            if (tag_id != want.tag_id)
                report_mismatch($sformatf("tag_id %h, expected %h", tag_id, want.tag_id));
            if (received_checksum != want.checksum)
                report_mismatch($sformatf("received_checksum %h, expected %h",
                                          received_checksum, want.checksum));
        end
    endtask

    task automatic advance_parser(input logic [7:0] b);
        logic [7:0]             v;
        logic [7:0]             pair;
        rfp_pkg::frame_result_t res;
        if (!parse_active)
        begin
            // Outside a frame only STX matters; everything else is dropped.
            if (b == rfp_pkg::CH_STX)
            begin
                parse_active    = 1'b1;
                char_index      = '0;
                high_char_value = '0;
                frame_xor       = '0;
                id_shift        = '0;
            end
        end
        else if (b == rfp_pkg::CH_STX || b == rfp_pkg::CH_ETX
                 || b == rfp_pkg::CH_CR || b == rfp_pkg::CH_LF)
        begin
            parse_active = 1'b0;
            char_index   = '0;
            res.status   = rfp_pkg::FRAME_ABORT;
            res.tag_id   = '0;
            res.checksum = '0;
            expected_frames.push_back(res);
        end
        else
        begin
            v = digit_value(b);
            if (!char_index[0])
            begin
                high_char_value = v;
                char_index      = char_index + 4'd1;
            end
            else
            begin
                // A raw character keeps all eight bits, so it is ORed over the shifted half.
                pair = v | {high_char_value[3:0], 4'h0};
                if ((char_index >> 1) < DATA_BYTES)
                begin
                    frame_xor  = frame_xor ^ pair;
                    id_shift   = (id_shift << 8) | IdWidth'(pair);
                    char_index = char_index + 4'd1;
                end
                else
                begin
                    parse_active = 1'b0;
                    char_index   = '0;
                    res.status   = (pair == frame_xor) ? rfp_pkg::FRAME_GOOD
                                                       : rfp_pkg::FRAME_BAD_SUM;
                    res.tag_id   = id_shift;
                    res.checksum = pair;
                    expected_frames.push_back(res);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_active    = 1'b0;
            char_index      = '0;
            high_char_value = '0;
            frame_xor       = '0;
            id_shift        = '0;
            expected_frames.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_frame();
            if (in_valid && in_ready)
                advance_parser(rx_byte);
            fail_count <= mismatches;
            pending    <= expected_frames.size();
        end
    end

endmodule

`default_nettype wire

// File: sim/tb_rfid_ascii_frame_parser_core.sv
// Testbench top for the tag-frame parser: drives reader bytes and result back-pressure,
// and gives the verdict from the failure count and the count of outstanding results of the frame checker.
// Depends on rfp_pkg, rfid_ascii_frame_parser_core and rfp_frame_checker.
`default_nettype none

module tb_rfid_ascii_frame_parser_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_BYTES   = 5;
    localparam int FRAME_TARGET = 750;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 4;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  frame_status;
    logic [39:0] tag_id;
    logic [7:0]  received_checksum;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int frame_bytes  = 0;
    int ready_hold   = 0;
    int kind;

    logic [7:0] opening_bytes [$];

    rfid_ascii_frame_parser_core #(
        .DATA_BYTES(DATA_BYTES)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .frame_status     (frame_status),
        .tag_id           (tag_id),
        .received_checksum(received_checksum)
    );

    rfp_frame_checker #(
        .DATA_BYTES(DATA_BYTES)
    ) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .frame_status     (frame_status),
        .tag_id           (tag_id),
        .received_checksum(received_checksum),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return rfp_pkg::CH_ZERO + 8'(n);
        return rfp_pkg::CH_A + (8'(n) - rfp_pkg::HEX_A_VALUE);
    endfunction

    function automatic logic [7:0] control_byte();
        case ($urandom_range(0, 3))
            0:       return rfp_pkg::CH_STX;
            1:       return rfp_pkg::CH_ETX;
            2:       return rfp_pkg::CH_CR;
            default: return rfp_pkg::CH_LF;
        endcase
    endfunction

    // Any byte that does not end a frame, lower-case hex and other raw values included.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == rfp_pkg::CH_STX || b == rfp_pkg::CH_ETX
               || b == rfp_pkg::CH_CR || b == rfp_pkg::CH_LF)
            b = 8'($urandom);
        return b;
    endfunction

    // Receiver back-pressure: alternating stretches of ready and stall.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold == 0)
        begin
            out_ready  <= !out_ready;
            ready_hold <= out_ready ? pick_gap() : $urandom_range(1, 40);
        end
        else
        begin
            ready_hold <= ready_hold - 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frame_bytes++;
    endtask

    // One frame of hex characters; optionally one character replaced by a raw byte,
    // and optionally cut short by a control byte after cut_at characters.
    task automatic send_frame(input bit corrupt, input int cut_at);
        logic [7:0] chars [$];
        logic [7:0] data;
        logic [7:0] sum;
        int         pos;
        sum = '0;
        chars.push_back(rfp_pkg::CH_STX);
        repeat (DATA_BYTES)
        begin
            data = 8'($urandom);
            sum  = sum ^ data;
            chars.push_back(hex_char(data[7:4]));
            chars.push_back(hex_char(data[3:0]));
        end
        if ($urandom_range(0, 3) == 0)
            sum = 8'($urandom);
        chars.push_back(hex_char(sum[7:4]));
        chars.push_back(hex_char(sum[3:0]));
        if (corrupt)
        begin
            pos        = $urandom_range(1, chars.size() - 1);
            chars[pos] = plain_byte();
        end
        if (cut_at > 0)
        begin
            while (chars.size() > cut_at)
                void'(chars.pop_back());
            chars.push_back(control_byte());
        end
        foreach (chars[i])
            send_byte(chars[i]);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = '0;
        // Idle junk, an all-F frame with a good checksum, then aborts by each
        // control byte, one of them after lower-case and non-hex characters.
        opening_bytes = '{8'h00, 8'hFF,
                          rfp_pkg::CH_STX, rfp_pkg::CH_F, rfp_pkg::CH_F, rfp_pkg::CH_F,
                          rfp_pkg::CH_F, rfp_pkg::CH_F, rfp_pkg::CH_F,
                          rfp_pkg::CH_F, rfp_pkg::CH_F, rfp_pkg::CH_F,
                          rfp_pkg::CH_F, rfp_pkg::CH_F, rfp_pkg::CH_F,
                          rfp_pkg::CH_STX, 8'h61, 8'h47, rfp_pkg::CH_LF,
                          rfp_pkg::CH_STX, rfp_pkg::CH_STX,
                          rfp_pkg::CH_STX, rfp_pkg::CH_CR,
                          rfp_pkg::CH_STX, rfp_pkg::CH_ETX};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);

        while (frame_bytes < FRAME_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
                send_frame(1'b0, 0);
            else if (kind < 78)
                send_frame(1'b1, 0);
            else if (kind < 88)
                send_frame(1'($urandom_range(0, 1)), $urandom_range(1, 2 * DATA_BYTES + 2));
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom));
                if ($urandom_range(0, 1) == 1)
                    send_byte(rfp_pkg::CH_ETX);
            end
        end
        in_valid <= 1'b0;

        // The checker's count of outstanding results is registered, so it lags the last beat.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
